// File: rtl/dpot_pkg.sv
// ----------------------------------------------------------------------------
// dpot_pkg: shared types and constants for the point outside test
// Register indexes, config field widths and the flag struct between stages.
// ----------------------------------------------------------------------------
package dpot_pkg;

    localparam int LW = 24;          // config length width, Q12.12
    localparam int CFG_W = 49;       // widest register
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_CRYSTAL = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROUND   = 3'd1;
    localparam logic [IDX_W-1:0] REG_CONTACT = 3'd2;
    localparam logic [IDX_W-1:0] REG_DITCH   = 3'd3;
    localparam logic [IDX_W-1:0] REG_WRAP    = 3'd4;
    localparam logic [IDX_W-1:0] REG_HOLE    = 3'd5;
    localparam logic [IDX_W-1:0] REG_OTAPER  = 3'd6;
    localparam logic [IDX_W-1:0] REG_ITAPER  = 3'd7;

    // unpacked configuration lengths
    typedef struct packed {
        logic [LW-1:0] zmax, rmax, br, hbr, pcl, pcr, dd, dt, wr, btl;
        logic [LW-1:0] hl, hr, otl, otw, itl, itw;
        logic          bullet;
    } t_cfg;

    // decision flags from the test stage to the combine stage
    typedef struct packed {
        logic range_out;   // z or r beyond the outer box
        logic top_out;
        logic pc_in;       // in contact region
        logic pc_out;
        logic btl_out;
        logic ditch_out;
        logic hole_in;
        logic hole_out;
        logic ot_out;
        logic it_out;
        logic cyl;
    } t_flags;

endpackage

// File: rtl/dpot_if.sv
// ----------------------------------------------------------------------------
// dpot_if: valid/ready stream channel
// Carries one word with a generic payload.
// ----------------------------------------------------------------------------
interface dpot_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/dpot_sqrt.sv
// ----------------------------------------------------------------------------
// dpot_sqrt: pipelined restoring integer square root
// Two result bits per stage; carries a side payload along with the root.
// ----------------------------------------------------------------------------
module dpot_sqrt #(
    parameter int RW = 24,     // root width
    parameter int SW = 1       // side payload width
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);
    localparam int NS = (RW + 1) / 2;
    localparam int RWE = 2 * NS;
    localparam int MW = RWE + 3;     // partial remainder width

    logic [2*RWE-1:0] r_rad  [NS+1];
    logic [MW-1:0]    r_rem  [NS+1];
    logic [RWE-1:0]   r_root [NS+1];
    logic [SW-1:0]    r_side [NS+1];
    logic [NS:0]      r_vld;

    always_comb begin
        r_rad[0]  = (2*RWE)'(i_rad);
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_side[0] = i_side;
        r_vld[0]  = i_valid;
    end

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [MW-1:0]  n_x1, n_t1, n_m1, n_x2, n_t2, n_rem;
        logic [RWE-1:0] n_r1, n_root;
        always_comb begin
            // first bit: bring down two radicand bits, try 4*root + 1
            n_x1 = {r_rem[s][MW-3:0], r_rad[s][2*RWE-1 -: 2]};
            n_t1 = MW'({r_root[s], 2'b01});
            if (n_x1 >= n_t1) begin
                n_m1 = n_x1 - n_t1;
                n_r1 = {r_root[s][RWE-2:0], 1'b1};
            end else begin
                n_m1 = n_x1;
                n_r1 = {r_root[s][RWE-2:0], 1'b0};
            end
            // second bit
            n_x2 = {n_m1[MW-3:0], r_rad[s][2*RWE-3 -: 2]};
            n_t2 = MW'({n_r1, 2'b01});
            if (n_x2 >= n_t2) begin
                n_rem  = n_x2 - n_t2;
                n_root = {n_r1[RWE-2:0], 1'b1};
            end else begin
                n_rem  = n_x2;
                n_root = {n_r1[RWE-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_rad[s+1]  <= r_rad[s] << 4;
                r_rem[s+1]  <= n_rem;
                r_root[s+1] <= n_root;
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_vld[NS];
    assign o_root  = r_root[NS][RW-1:0];
    assign o_side  = r_side[NS];
endmodule

// File: rtl/dpot_test.sv
// ----------------------------------------------------------------------------
// dpot_test: geometry tests on (r, z)
// Stage A: differences. Stage B: squares and products. Stage C: compares.
// ----------------------------------------------------------------------------
module dpot_test #(
    parameter int CW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic                 i_cyl,
    input  logic signed [CW:0]   i_r,
    input  logic signed [CW-1:0] i_z,
    input  dpot_pkg::t_cfg       i_cfg,
    output logic                 o_valid,
    output dpot_pkg::t_flags     o_flags
);
    localparam int DW = (CW > dpot_pkg::LW ? CW : dpot_pkg::LW) + 3;  // differences
    localparam int PW = 2 * DW + 2;                                  // products

    typedef logic signed [DW-1:0] t_d;
    typedef logic signed [PW-1:0] t_p;

    dpot_pkg::t_cfg c;
    assign c = i_cfg;

    function automatic t_d ex(input logic [dpot_pkg::LW-1:0] v);
        return t_d'({1'b0, v});
    endfunction

    // full-width signed product of two differences
    function automatic t_p mul(input t_d x, input t_d y);
        return t_p'(x) * t_p'(y);
    endfunction

    // ---------------- stage A: differences and plain compares
    t_d r, z;
    assign r = t_d'(i_r);
    assign z = t_d'(i_z);

    logic r_va, r_cyl_a;
    t_d   r_d, r_e, r_zp, r_rp, r_zh, r_rh, r_zb, r_rb, r_ro, r_to, r_ri, r_ti;
    t_d   r_br, r_pcr, r_pcl, r_hbr;
    logic r_range, r_top_en, r_pc_in, r_pcl_gt, r_pc_near, r_btl_out, r_ditch;
    logic r_hole_in, r_hole_b, r_hole_a, r_ot_en, r_it_en, r_e_pos;

    t_d n_a, n_b;
    always_comb begin
        n_a = (ex(c.pcl) > ex(c.pcr)) ? ex(c.pcl) - ex(c.pcr) : ex(c.pcr) - ex(c.pcl);
        n_b = ex(c.zmax) - ex(c.hl) + ex(c.hbr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
        if (i_en) begin
            r_cyl_a   <= i_cyl;
            r_range   <= (z > ex(c.zmax)) || (z < 0) || (r > ex(c.rmax));
            r_top_en  <= z > ex(c.zmax) - ex(c.br);
            r_d       <= z - (ex(c.zmax) - ex(c.br));
            r_e       <= r - (ex(c.rmax) - ex(c.br));
            r_e_pos   <= r - (ex(c.rmax) - ex(c.br)) > 0;
            r_pc_in   <= (c.pcr != '0) && (z < ex(c.pcl)) && (r < ex(c.pcr));
            r_pcl_gt  <= ex(c.pcl) > ex(c.pcr);
            r_pc_near <= (ex(c.pcl) > ex(c.pcr)) ? (z < n_a) : (r < n_a);
            r_zp      <= (ex(c.pcl) > ex(c.pcr)) ? z - n_a : z;
            r_rp      <= (ex(c.pcl) > ex(c.pcr)) ? r : r - n_a;
            r_btl_out <= (c.btl != '0) && (z < ex(c.btl))
                         && (r > ex(c.zmax) - ex(c.btl) + z);
            r_ditch   <= (c.dd != '0) && (z < ex(c.dd)) && (c.dt != '0) && (c.wr != '0)
                         && (r < ex(c.wr)) && (r > ex(c.wr) - ex(c.dt));
            r_hole_in <= (r < ex(c.hr)) && (z > ex(c.zmax) - ex(c.hl));
            r_hole_b  <= z > n_b;
            r_hole_a  <= r < ex(c.hr) - ex(c.hbr);
            r_zh      <= n_b - z;
            r_rh      <= r - (ex(c.hr) - ex(c.hbr));
            r_ot_en   <= (c.otl != '0) && (z > ex(c.zmax) - ex(c.otl));
            r_ro      <= r - ex(c.rmax);
            r_to      <= z - ex(c.zmax) + ex(c.otl);
            r_it_en   <= (c.itl != '0) && (z > ex(c.zmax) - ex(c.itl));
            r_ri      <= r - ex(c.hr);
            r_ti      <= z - ex(c.zmax) + ex(c.itl);
            r_br      <= ex(c.br);
            r_pcr     <= ex(c.pcr);
            r_pcl     <= ex(c.pcl);
            r_hbr     <= ex(c.hbr);
        end
    end

    // ---------------- stage B: squares and cross products
    logic r_vb, r_cyl_b;
    logic r_range_b, r_top_en_b, r_e_pos_b, r_pc_in_b, r_pc_near_b, r_btl_b;
    logic r_ditch_b, r_hole_in_b, r_hole_b_b, r_hole_a_b, r_ot_en_b, r_it_en_b;
    logic r_pcl_gt_b;
    t_p   r_sbr, r_sd, r_se, r_sz, r_sr, r_spc, r_szh, r_srh, r_shb;
    t_p   r_po1, r_po2, r_pi1, r_pi2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_vb <= r_va;
        end
        if (i_en) begin
            r_cyl_b     <= r_cyl_a;
            r_range_b   <= r_range;
            r_top_en_b  <= r_top_en;
            r_e_pos_b   <= r_e_pos;
            r_pc_in_b   <= r_pc_in;
            r_pcl_gt_b  <= r_pcl_gt;
            r_pc_near_b <= r_pc_near;
            r_btl_b     <= r_btl_out;
            r_ditch_b   <= r_ditch;
            r_hole_in_b <= r_hole_in;
            r_hole_b_b  <= r_hole_b;
            r_hole_a_b  <= r_hole_a;
            r_ot_en_b   <= r_ot_en;
            r_it_en_b   <= r_it_en;
            r_sbr       <= mul(r_br, r_br);
            r_sd        <= mul(r_d, r_d);
            r_se        <= mul(r_e, r_e);
            r_sz        <= mul(r_zp, r_zp);
            r_sr        <= mul(r_rp, r_rp);
            r_spc       <= r_pcl_gt ? mul(r_pcr, r_pcr) : mul(r_pcl, r_pcl);
            r_szh       <= mul(r_zh, r_zh);
            r_srh       <= mul(r_rh, r_rh);
            r_shb       <= mul(r_hbr, r_hbr);
            r_po1       <= mul(r_ro, ex(c.otl));
            r_po2       <= mul(r_to, ex(c.otw));
            r_pi1       <= mul(r_ri, ex(c.itl));
            r_pi2       <= mul(r_ti, ex(c.itw));
        end
    end

    // ---------------- stage C: final compares
    t_p n_q;
    dpot_pkg::t_flags n_f;
    always_comb begin
        n_q = r_sbr - r_sd;
        if (n_q < 0) begin
            n_q = '0;
        end
        n_f.range_out = r_range_b;
        n_f.top_out   = r_top_en_b && r_e_pos_b && (r_se > n_q);
        n_f.pc_in     = r_pc_in_b;
        n_f.pc_out    = !c.bullet || r_pc_near_b || (r_sz + r_sr < r_spc);
        n_f.btl_out   = r_btl_b;
        n_f.ditch_out = r_ditch_b;
        n_f.hole_in   = r_hole_in_b;
        n_f.hole_out  = r_hole_b_b || r_hole_a_b || (r_szh + r_srh < r_shb);
        n_f.ot_out    = r_ot_en_b && (r_po1 + r_po2 > 0);
        n_f.it_out    = r_it_en_b && (r_pi1 < r_pi2);
        n_f.cyl       = r_cyl_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vb;
        end
        if (i_en) begin
            o_flags <= n_f;
        end
    end
endmodule

// File: rtl/detector_point_outside_test.sv
// ----------------------------------------------------------------------------
// detector_point_outside_test: point outside test for a point-contact crystal
// Pipeline: radius stages (squares, sum), ceil((COORD_WIDTH+1)/2) root stages, 3 test
// stages and 1 output register. Throughput: one word per cycle while the output
// register is free or being drained; the whole pipeline advances only then.
// Reset clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module detector_point_outside_test #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dpot_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [dpot_pkg::CFG_W-1:0]    i_cfg_data,
    dpot_if.sink                          s_in,
    dpot_if.source                        m_out
);
    localparam int CW = COORD_WIDTH;
    localparam int RW = CW + 1;     // radius width, unsigned root of a 2*CW+2 bit sum

    // input word: {op, coord_a, coord_b, coord_z}
    logic                 op;
    logic signed [CW-1:0] coord_a, coord_b, coord_z;
    assign {op, coord_a, coord_b, coord_z} = s_in.data;

    // configuration registers
    logic [47:0] r_crys, r_cont, r_dit, r_wrap, r_hole, r_ot, r_it;
    logic [48:0] r_rnd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crys <= '0; r_rnd <= '0; r_cont <= '0; r_dit <= '0;
            r_wrap <= '0; r_hole <= '0; r_ot <= '0; r_it <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpot_pkg::REG_CRYSTAL: r_crys <= i_cfg_data[47:0];
                dpot_pkg::REG_ROUND:   r_rnd  <= i_cfg_data[48:0];
                dpot_pkg::REG_CONTACT: r_cont <= i_cfg_data[47:0];
                dpot_pkg::REG_DITCH:   r_dit  <= i_cfg_data[47:0];
                dpot_pkg::REG_WRAP:    r_wrap <= i_cfg_data[47:0];
                dpot_pkg::REG_HOLE:    r_hole <= i_cfg_data[47:0];
                dpot_pkg::REG_OTAPER:  r_ot   <= i_cfg_data[47:0];
                dpot_pkg::REG_ITAPER:  r_it   <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    dpot_pkg::t_cfg cfg;
    always_comb begin
        cfg.zmax = r_crys[47:24]; cfg.rmax = r_crys[23:0];
        cfg.bullet = r_rnd[48]; cfg.hbr = r_rnd[47:24]; cfg.br = r_rnd[23:0];
        cfg.pcl = r_cont[47:24]; cfg.pcr = r_cont[23:0];
        cfg.dd = r_dit[47:24]; cfg.dt = r_dit[23:0];
        cfg.wr = r_wrap[47:24]; cfg.btl = r_wrap[23:0];
        cfg.hl = r_hole[47:24]; cfg.hr = r_hole[23:0];
        cfg.otl = r_ot[47:24]; cfg.otw = r_ot[23:0];
        cfg.itl = r_it[47:24]; cfg.itw = r_it[23:0];
    end

    // pipeline enable: output register free or being taken
    logic en;
    assign en = !m_out.valid || m_out.ready;
    assign s_in.ready = en;

    // stage 1: squares
    logic              r_v1, r_op1;
    logic [2*CW-1:0]   r_sa, r_sb;
    logic signed [CW:0] r_a1;
    logic signed [CW-1:0] r_z1;
    logic [CW-1:0]     n_ma, n_mb;
    assign n_ma = coord_a[CW-1] ? CW'(-coord_a) : coord_a;
    assign n_mb = coord_b[CW-1] ? CW'(-coord_b) : coord_b;
    // most negative value: -x wraps to itself, which as unsigned is 2^(CW-1): correct

    // stage 2: sum
    logic              r_v2, r_op2;
    logic [2*RW-1:0]   r_sum;
    logic signed [CW:0] r_a2;
    logic signed [CW-1:0] r_z2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_in.valid; r_v2 <= r_v1;
        end
        if (en) begin
            r_op1 <= op; r_a1 <= (CW+1)'(coord_a); r_z1 <= coord_z;
            r_sa  <= n_ma * n_ma; r_sb <= n_mb * n_mb;
            r_op2 <= r_op1; r_a2 <= r_a1; r_z2 <= r_z1;
            r_sum <= (2*RW)'(r_sa) + (2*RW)'(r_sb);
        end
    end

    // square root, with op/a/z riding along
    localparam int SW = 1 + (CW + 1) + CW;
    logic          sq_v;
    logic [RW-1:0] sq_root;
    logic [SW-1:0] sq_side;
    dpot_sqrt #(.RW(RW), .SW(SW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_v2), .i_rad(r_sum), .i_side({r_op2, r_a2, r_z2}),
        .o_valid(sq_v), .o_root(sq_root), .o_side(sq_side)
    );

    logic                 t_op;
    logic signed [CW:0]   t_a, t_r;
    logic signed [CW-1:0] t_z;
    assign {t_op, t_a, t_z} = sq_side;
    assign t_r = t_op ? t_a : $signed(sq_root);

    logic             tv;
    dpot_pkg::t_flags f;
    dpot_test #(.CW(CW)) u_test (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(sq_v), .i_cyl(t_op), .i_r(t_r), .i_z(t_z), .i_cfg(cfg),
        .o_valid(tv), .o_flags(f)
    );

    // combine flags in the order of the tests
    logic n_out;
    always_comb begin
        if (f.range_out || f.top_out) begin
            n_out = 1'b1;
        end else if (f.pc_in) begin
            n_out = f.pc_out;
        end else if (f.btl_out || f.ditch_out) begin
            n_out = 1'b1;
        end else if (f.hole_in && f.hole_out) begin
            n_out = 1'b1;
        end else if (f.hole_in && !f.cyl) begin
            n_out = 1'b0;
        end else begin
            n_out = f.ot_out || f.it_out;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_out.valid <= 1'b0;
        end else if (en) begin
            m_out.valid <= tv;
        end
        if (en) begin
            m_out.data <= n_out;
        end
    end
endmodule
